@@ rtl/core/tnes_pkg.sv @@
//------------------------------------------------------------------------------
// Tracker note event scheduler package
// Shared types, microcode word layout, step addresses and constants.
//------------------------------------------------------------------------------
`default_nettype none

package tnes_pkg;

    localparam int unsigned STEP_W = 4;

    typedef enum logic [2:0] {
        M_NONE,
        M_ROWS,
        M_SWING,
        M_START,
        M_RECIP,
        M_GATE
    } t_mul_sel;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_REQ,
        J_SINGLE,
        J_GOTO,
        J_EMIT
    } t_jmp;

    typedef struct packed {
        t_mul_sel          mul_sel;
        logic              ld_row;
        logic              ld_sw;
        logic              ld_start;
        logic              ld_quot;
        logic              ld_dur;
        logic              ld_time;
        logic              emit;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic failed;
        logic single;
        logic fire;
        logic done;
    } t_status;

    typedef struct packed {
        logic [30:0] row_step;
        logic [14:0] swing;
        logic [6:0]  rows;
        logic [47:0] arp1;
        logic [47:0] arp2;
        logic [63:0] slow_mask;
        logic [63:0] start_sample;
        logic [31:0] group_id;
    } t_cfg;

    localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MROWS   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ROW     = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SW      = 4'd3;
    localparam logic [STEP_W-1:0] STEP_START   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MRECIP  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_QUOT    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MGATE   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DUR     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_TIME    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd10;

    localparam logic [2:0] CFG_ROW_STEP     = 3'd0;
    localparam logic [2:0] CFG_SWING        = 3'd1;
    localparam logic [2:0] CFG_ROWS         = 3'd2;
    localparam logic [2:0] CFG_ARP_FIRST    = 3'd3;
    localparam logic [2:0] CFG_ARP_SECOND   = 3'd4;
    localparam logic [2:0] CFG_SLOW_MASK    = 3'd5;
    localparam logic [2:0] CFG_START_SAMPLE = 3'd6;
    localparam logic [2:0] CFG_GROUP_ID     = 3'd7;

    localparam logic [30:0] ROW_STEP_RESET = 31'd393216000;
    localparam logic [6:0]  ROWS_RESET     = 7'd8;

    // floor(x / 3) = (x * RECIP3) >> 33 for any 32-bit x
    localparam logic [31:0] RECIP3     = 32'hAAAAAAAB;
    localparam int unsigned RECIP3_SH  = 33;
    localparam logic [31:0] GATE_Q16   = 32'd55706;
    localparam logic [6:0]  PITCH_MIN  = 7'd1;
    localparam logic [6:0]  PITCH_MAX  = 7'd127;
    localparam logic [6:0]  GAIN_MAX   = 7'd100;

endpackage

`default_nettype wire

@@ rtl/core/tnes_ucode_rom.sv @@
//------------------------------------------------------------------------------
// Tracker note event scheduler microcode ROM
// One control word per step of the per-note program.
//------------------------------------------------------------------------------
`default_nettype none

module tnes_ucode_rom (
    input  wire logic [tnes_pkg::STEP_W-1:0] i_step,
    output tnes_pkg::t_uop                   o_uop
);

    always_comb begin
        o_uop         = '0;
        o_uop.mul_sel = tnes_pkg::M_NONE;
        o_uop.jmp     = tnes_pkg::J_NEXT;
        o_uop.target  = tnes_pkg::STEP_FETCH;
        unique case (i_step)
            tnes_pkg::STEP_FETCH: begin
                o_uop.jmp    = tnes_pkg::J_WAIT_REQ;
                o_uop.target = tnes_pkg::STEP_EMIT;
            end
            tnes_pkg::STEP_MROWS: begin
                o_uop.mul_sel = tnes_pkg::M_ROWS;
            end
            tnes_pkg::STEP_ROW: begin
                o_uop.ld_row  = 1'b1;
                o_uop.mul_sel = tnes_pkg::M_SWING;
            end
            tnes_pkg::STEP_SW: begin
                o_uop.ld_sw   = 1'b1;
                o_uop.mul_sel = tnes_pkg::M_START;
            end
            tnes_pkg::STEP_START: begin
                o_uop.ld_start = 1'b1;
                o_uop.jmp      = tnes_pkg::J_SINGLE;
                o_uop.target   = tnes_pkg::STEP_MGATE;
            end
            tnes_pkg::STEP_MRECIP: begin
                o_uop.mul_sel = tnes_pkg::M_RECIP;
            end
            tnes_pkg::STEP_QUOT: begin
                o_uop.ld_quot = 1'b1;
            end
            tnes_pkg::STEP_MGATE: begin
                o_uop.mul_sel = tnes_pkg::M_GATE;
            end
            tnes_pkg::STEP_DUR: begin
                o_uop.ld_dur = 1'b1;
            end
            tnes_pkg::STEP_TIME: begin
                o_uop.ld_time = 1'b1;
            end
            tnes_pkg::STEP_EMIT: begin
                o_uop.emit   = 1'b1;
                o_uop.jmp    = tnes_pkg::J_EMIT;
                o_uop.target = tnes_pkg::STEP_TIME;
            end
            default: begin
                o_uop.jmp    = tnes_pkg::J_GOTO;
                o_uop.target = tnes_pkg::STEP_FETCH;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/tnes_sequencer.sv @@
//------------------------------------------------------------------------------
// Tracker note event scheduler sequencer
// Step counter with conditional jumps over the microcode ROM.
//------------------------------------------------------------------------------
`default_nettype none

module tnes_sequencer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tnes_pkg::t_status i_status,
    output tnes_pkg::t_uop         o_uop,
    output logic                   o_ready
);

    logic [tnes_pkg::STEP_W-1:0] r_step;
    logic [tnes_pkg::STEP_W-1:0] n_step;
    logic [tnes_pkg::STEP_W-1:0] w_inc;

    tnes_ucode_rom u_rom (
        .i_step (r_step),
        .o_uop  (o_uop)
    );

    assign w_inc   = r_step + {{(tnes_pkg::STEP_W-1){1'b0}}, 1'b1};
    assign o_ready = (o_uop.jmp == tnes_pkg::J_WAIT_REQ);

    always_comb begin
        n_step = w_inc;
        unique case (o_uop.jmp)
            tnes_pkg::J_NEXT: begin
                n_step = w_inc;
            end
            tnes_pkg::J_WAIT_REQ: begin
                if (!i_status.accept) begin
                    n_step = r_step;
                end else if (i_status.failed) begin
                    n_step = o_uop.target;
                end
            end
            tnes_pkg::J_SINGLE: begin
                if (i_status.single) begin
                    n_step = o_uop.target;
                end
            end
            tnes_pkg::J_GOTO: begin
                n_step = o_uop.target;
            end
            tnes_pkg::J_EMIT: begin
                if (!i_status.fire) begin
                    n_step = r_step;
                end else if (i_status.done) begin
                    n_step = tnes_pkg::STEP_FETCH;
                end else begin
                    n_step = o_uop.target;
                end
            end
            default: begin
                n_step = tnes_pkg::STEP_FETCH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= tnes_pkg::STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tnes_datapath.sv @@
//------------------------------------------------------------------------------
// Tracker note event scheduler datapath
// Shared multiplier, timing registers, voice counter and result register.
//------------------------------------------------------------------------------
`default_nettype none

module tnes_datapath #(
    parameter int unsigned MAX_PATCHES = 64,
    parameter int unsigned CHANNELS    = 8,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tnes_pkg::t_cfg     i_cfg,
    input  wire tnes_pkg::t_uop     i_uop,
    input  wire logic               i_accept,
    input  wire logic [6:0]         i_order_index,
    input  wire logic [5:0]         i_note_row,
    input  wire logic [2:0]         i_channel,
    input  wire logic [6:0]         i_note_pitch,
    input  wire logic [6:0]         i_patch,
    input  wire logic [6:0]         i_volume,
    input  wire logic signed [5:0]  i_effect,
    input  wire logic               i_out_ready,
    output tnes_pkg::t_status       o_status,
    output logic                    o_out_valid,
    output logic [63:0]             o_sample_time,
    output logic [31:0]             o_voice_id,
    output logic [31:0]             o_group,
    output logic [6:0]              o_patch_out,
    output logic [6:0]              o_pitch,
    output logic [6:0]              o_gain_percent,
    output logic [16:0]             o_duration_samples,
    output logic                    o_last,
    output logic                    o_error
);

    logic [6:0]        r_order;
    logic [5:0]        r_nrow;
    logic [2:0]        r_ch;
    logic [6:0]        r_note;
    logic [6:0]        r_patch;
    logic [6:0]        r_vol;
    logic [5:0]        r_effect;

    logic [63:0]       r_prod;
    logic [12:0]       r_row;
    logic [29:0]       r_sw;
    logic [43:0]       r_start;
    logic [31:0]       r_len;
    logic [30:0]       r_quot;
    logic [31:0]       r_off2;
    logic [16:0]       r_dur;
    logic [44:0]       r_t;
    logic [6:0]        r_pitch;
    logic [1:0]        r_idx;
    logic [31:0]       r_voice;
    logic              r_failed;
    logic              r_out_valid;

    logic [6:0]        w_rows;
    logic [31:0]       w_ma;
    logic [31:0]       w_mb;
    logic [5:0]        w_a1;
    logic [5:0]        w_a2;
    logic [5:0]        w_arp;
    logic              w_single;
    logic              w_slow;
    logic [5:0]        w_pidx;
    logic [31:0]       w_three_q;
    logic [31:0]       w_rem;
    logic [31:0]       w_off;
    logic signed [8:0] w_psum;
    logic [6:0]        w_pclamp;
    logic              w_err;
    logic              w_fire;
    logic              w_done;

    always_comb begin
        w_rows = i_cfg.rows;
        priority if (i_cfg.rows == 7'd0) begin
            w_rows = 7'd1;
        end else if (i_cfg.rows > 7'(MAX_ROWS)) begin
            w_rows = 7'(MAX_ROWS);
        end
    end

    always_comb begin
        w_a1 = 6'd0;
        w_a2 = 6'd0;
        if ({1'b0, r_ch} < 4'(CHANNELS)) begin
            w_a1 = i_cfg.arp1[6*r_ch +: 6];
            w_a2 = i_cfg.arp2[6*r_ch +: 6];
        end
    end

    assign w_single = (w_a1 == 6'd0) && (w_a2 == 6'd0);
    assign w_pidx   = 6'(r_patch - 7'd1);
    assign w_slow   = (r_patch != 7'd0) && (r_patch <= 7'(MAX_PATCHES))
                      && i_cfg.slow_mask[w_pidx];

    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        unique case (i_uop.mul_sel)
            tnes_pkg::M_NONE: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
            tnes_pkg::M_ROWS: begin
                w_ma = 32'(w_rows);
                w_mb = 32'(r_order);
            end
            tnes_pkg::M_SWING: begin
                w_ma = 32'(i_cfg.row_step);
                w_mb = 32'(i_cfg.swing);
            end
            tnes_pkg::M_START: begin
                w_ma = 32'(r_row);
                w_mb = 32'(i_cfg.row_step);
            end
            tnes_pkg::M_RECIP: begin
                w_ma = r_len;
                w_mb = tnes_pkg::RECIP3;
            end
            tnes_pkg::M_GATE: begin
                w_ma = w_single ? r_len : 32'(r_quot);
                w_mb = tnes_pkg::GATE_Q16;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    assign w_three_q = {r_quot, 1'b0} + 32'(r_quot);
    assign w_rem     = r_len - w_three_q;

    always_comb begin
        w_off = 32'd0;
        w_arp = 6'd0;
        unique case (r_idx)
            2'd0: begin
                w_off = 32'd0;
                w_arp = 6'd0;
            end
            2'd1: begin
                w_off = 32'(r_quot);
                w_arp = w_a1;
            end
            default: begin
                w_off = r_off2;
                w_arp = w_a2;
            end
        endcase
    end

    assign w_psum = $signed({2'b00, r_note}) + $signed({{3{r_effect[5]}}, r_effect})
                    + $signed({{3{w_arp[5]}}, w_arp});

    always_comb begin
        w_pclamp = w_psum[6:0];
        priority if (w_psum < 9'sd1) begin
            w_pclamp = tnes_pkg::PITCH_MIN;
        end else if (w_psum > 9'sd127) begin
            w_pclamp = tnes_pkg::PITCH_MAX;
        end
    end

    assign w_err  = r_failed || (r_voice == 32'hFFFF_FFFF);
    assign w_fire = i_uop.emit && (!r_out_valid || i_out_ready);
    assign w_done = w_err || (r_idx == (w_single ? 2'd0 : 2'd2));

    assign o_status.accept = i_accept;
    assign o_status.failed = r_failed;
    assign o_status.single = w_single;
    assign o_status.fire   = w_fire;
    assign o_status.done   = w_done;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);

        if (i_accept) begin
            r_order  <= i_order_index;
            r_nrow   <= i_note_row;
            r_ch     <= i_channel;
            r_note   <= i_note_pitch;
            r_patch  <= i_patch;
            r_vol    <= i_volume;
            r_effect <= i_effect;
        end
        if (i_uop.ld_row) begin
            r_row <= r_prod[12:0] + 13'(r_nrow);
        end
        if (i_uop.ld_sw) begin
            r_sw <= r_prod[45:16];
        end
        if (i_uop.ld_start) begin
            r_start <= r_prod[43:0] + (r_row[0] ? 44'(r_sw) : 44'd0);
            r_len   <= r_row[0] ? 32'(i_cfg.row_step) - 32'(r_sw)
                                : 32'(i_cfg.row_step) + 32'(r_sw);
        end
        if (i_uop.ld_quot) begin
            r_quot <= r_prod[63:tnes_pkg::RECIP3_SH];
        end
        if (i_uop.ld_dur) begin
            r_dur  <= w_slow ? i_cfg.row_step[30:14] : {1'b0, r_prod[47:32]};
            r_off2 <= {r_quot, 1'b0} + 32'(w_rem == 32'd2);
        end
        if (i_uop.ld_time) begin
            r_t     <= 45'(r_start) + 45'(w_off);
            r_pitch <= w_pclamp;
        end
        if (w_fire) begin
            if (w_err) begin
                o_sample_time      <= 64'd0;
                o_voice_id         <= 32'd0;
                o_group            <= 32'd0;
                o_patch_out        <= 7'd0;
                o_pitch            <= 7'd0;
                o_gain_percent     <= 7'd0;
                o_duration_samples <= 17'd0;
                o_last             <= 1'b1;
                o_error            <= 1'b1;
            end else begin
                o_sample_time      <= i_cfg.start_sample + 64'(r_t[44:16]);
                o_voice_id         <= r_voice + 32'd1;
                o_group            <= i_cfg.group_id;
                o_patch_out        <= r_patch;
                o_pitch            <= r_pitch;
                o_gain_percent     <= (r_vol > tnes_pkg::GAIN_MAX) ? tnes_pkg::GAIN_MAX
                                                                   : r_vol;
                o_duration_samples <= r_dur;
                o_last             <= w_done;
                o_error            <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice     <= 32'd0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (i_uop.ld_dur) begin
                r_idx <= 2'd0;
            end else if (w_fire && !w_err) begin
                r_idx <= r_idx + 2'd1;
            end
            if (w_fire) begin
                if (w_err) begin
                    r_failed <= 1'b1;
                end else begin
                    r_voice <= r_voice + 32'd1;
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tracker_note_event_scheduler_top.sv @@
// Each note runs the microcode program in order; arpeggio notes also take the
// reciprocal and quotient steps, and each further command repeats time and emit.
// A new note is accepted only once the last command of the previous note issues;
// the program uses one shared 32x32 multiplier, and output back-pressure stalls it.
// Reset: synchronous active-low; clears voice counter, failure flag and step counter,
// loads configuration reset values.
//------------------------------------------------------------------------------
// Tracker note event scheduler top level
// Configuration registers, handshakes, sequencer and datapath.
//------------------------------------------------------------------------------
`default_nettype none

module tracker_note_event_scheduler_top #(
    parameter int unsigned MAX_PATCHES = 64,
    parameter int unsigned CHANNELS    = 8,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [6:0]         i_order_index,
    input  wire logic [5:0]         i_note_row,
    input  wire logic [2:0]         i_channel,
    input  wire logic [6:0]         i_note_pitch,
    input  wire logic [6:0]         i_patch,
    input  wire logic [6:0]         i_volume,
    input  wire logic signed [5:0]  i_effect,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [63:0]             o_sample_time,
    output logic [31:0]             o_voice_id,
    output logic [31:0]             o_group,
    output logic [6:0]              o_patch_out,
    output logic [6:0]              o_pitch,
    output logic [6:0]              o_gain_percent,
    output logic [16:0]             o_duration_samples,
    output logic                    o_last,
    output logic                    o_error
);

    tnes_pkg::t_cfg    r_cfg;
    tnes_pkg::t_uop    w_uop;
    tnes_pkg::t_status w_status;
    logic              w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_step     <= tnes_pkg::ROW_STEP_RESET;
            r_cfg.swing        <= 15'd0;
            r_cfg.rows         <= tnes_pkg::ROWS_RESET;
            r_cfg.arp1         <= 48'd0;
            r_cfg.arp2         <= 48'd0;
            r_cfg.slow_mask    <= 64'd0;
            r_cfg.start_sample <= 64'd0;
            r_cfg.group_id     <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tnes_pkg::CFG_ROW_STEP:     r_cfg.row_step     <= i_cfg_data[30:0];
                tnes_pkg::CFG_SWING:        r_cfg.swing        <= i_cfg_data[14:0];
                tnes_pkg::CFG_ROWS:         r_cfg.rows         <= i_cfg_data[6:0];
                tnes_pkg::CFG_ARP_FIRST:    r_cfg.arp1         <= i_cfg_data[47:0];
                tnes_pkg::CFG_ARP_SECOND:   r_cfg.arp2         <= i_cfg_data[47:0];
                tnes_pkg::CFG_SLOW_MASK:    r_cfg.slow_mask    <= i_cfg_data;
                tnes_pkg::CFG_START_SAMPLE: r_cfg.start_sample <= i_cfg_data;
                tnes_pkg::CFG_GROUP_ID:     r_cfg.group_id     <= i_cfg_data[31:0];
                default:                    r_cfg.group_id     <= r_cfg.group_id;
            endcase
        end
    end

    tnes_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_uop    (w_uop),
        .o_ready  (o_in_ready)
    );

    tnes_datapath #(
        .MAX_PATCHES (MAX_PATCHES),
        .CHANNELS    (CHANNELS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_uop              (w_uop),
        .i_accept           (w_accept),
        .i_order_index      (i_order_index),
        .i_note_row         (i_note_row),
        .i_channel          (i_channel),
        .i_note_pitch       (i_note_pitch),
        .i_patch            (i_patch),
        .i_volume           (i_volume),
        .i_effect           (i_effect),
        .i_out_ready        (i_out_ready),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .o_sample_time      (o_sample_time),
        .o_voice_id         (o_voice_id),
        .o_group            (o_group),
        .o_patch_out        (o_patch_out),
        .o_pitch            (o_pitch),
        .o_gain_percent     (o_gain_percent),
        .o_duration_samples (o_duration_samples),
        .o_last             (o_last),
        .o_error            (o_error)
    );

`ifndef NO_ASSERTIONS
    a_voice_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_voice_id != 32'd0 && o_pitch != 7'd0)
        else $error("command with zero voice id or pitch");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last && o_voice_id == 32'd0 && o_sample_time == 64'd0)
        else $error("malformed error result");

    a_failed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.failed |=> w_status.failed)
        else $error("failure flag cleared without reset");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.fire |-> !o_in_ready)
        else $error("request taken while a command is issued");
`endif

endmodule

`default_nettype wire
